FILE: design/fenced_ring_staging_allocator_core_macros.svh
// assertion macros for the staging ring allocator
`ifndef FENCED_RING_STAGING_ALLOCATOR_CORE_MACROS_SVH
`define FENCED_RING_STAGING_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FRSA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frsa assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define FRSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frsa assertion failed");

`endif

FILE: design/frsa_pkg.sv
`default_nettype none

package frsa_pkg;

	localparam int OFS_W    = 32;
	localparam int FENCE_W  = 64;
	localparam int SIZE_W   = 32;
	localparam int ALIGN_W  = 17;
	localparam int IFL_W    = OFS_W + FENCE_W;

	localparam logic [31:0] RING_SIZE_RESET = 32'd1048576;

	// request codes
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_SUBMIT = 2'd1;
	localparam logic [1:0] ACT_BEGIN  = 2'd2;

	// result codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

FILE: design/frsa_ram.sv
`default_nettype none

// one write port, one registered read port
module frsa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/fenced_ring_staging_allocator_core.sv
// allocate: one read of the in-flight head slot, then the placement and the result
// submit: per pending entry, a pending read, then an in-flight write
// begin frame: per retired entry, a fence read, then a compare
// one item at a time; the next beat is taken once the result sits in the output register
// reset (arst_n low): head, counts, fifo pointers and output valid clear, ring size to 1 MiB;
// the pending and in-flight memories are not cleared and need no clearing pass
`default_nettype none

module fenced_ring_staging_allocator_core
	import frsa_pkg::*;
#(
	parameter int PENDING_DEPTH  = 64,
	parameter int INFLIGHT_DEPTH = 256,
	parameter int OFFSET_BITS    = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration: ring size
	input  wire logic               cfg_wen,
	input  wire logic [31:0]        cfg_wdata,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic [SIZE_W-1:0]  alloc_size,
	input  wire logic [ALIGN_W-1:0] alignment,
	input  wire logic [FENCE_W-1:0] fence,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [OFS_W-1:0]        offset
);

	// pending list index and count widths
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	// in-flight slot width; a phase bit per pointer tells full from empty
	localparam int IIW = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
	// aligned head: wide enough for head plus alignment mask, at most 64 bits
	localparam int AXW = (OFFSET_BITS >= 64) ? 64
		: (((OFFSET_BITS > ALIGN_W) ? OFFSET_BITS : ALIGN_W) + 1);
	// aligned head plus size, compared against ring size and tail
	localparam int SUMW = (AXW >= 64) ? 64 : (((AXW > OFS_W) ? AXW : OFS_W) + 1);
	// placed offset plus size, before folding into the head width
	localparam int HSW = (OFFSET_BITS > OFS_W + 1) ? OFFSET_BITS : (OFS_W + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ALLOC  = 7'b0000010,
		S_SUB_RD = 7'b0000100,
		S_SUB_WR = 7'b0001000,
		S_BF_RD  = 7'b0010000,
		S_BF_CMP = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	// control state
	state_t                 state_q, state_d;
	logic [31:0]            ring_size_q;
	logic [OFFSET_BITS-1:0] head_q, head_d;
	logic [PCW-1:0]         pcount_q, pcount_d;
	logic [PCW-1:0]         pidx_q, pidx_d;
	logic [IIW-1:0]         rslot_q, rslot_d;
	logic                   rph_q, rph_d;
	logic [IIW-1:0]         wslot_q, wslot_d;
	logic                   wph_q, wph_d;
	logic                   out_valid_q, out_valid_d;

	// captured request and held result
	logic [SIZE_W-1:0]      size_q;
	logic [FENCE_W-1:0]     fence_q;
	logic [AXW-1:0]         aligned_q;
	logic [1:0]             res_status_q;
	logic [OFS_W-1:0]       res_offset_q;
	logic [1:0]             status_q;
	logic [OFS_W-1:0]       offset_q;

	// memory ports
	logic                   pend_we;
	logic [OFS_W-1:0]       pend_rdata;
	logic                   ifl_we;
	logic [IFL_W-1:0]       ifl_rdata;

	// datapath
	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic                   fifo_empty;
	logic                   fifo_full;
	logic [ALIGN_W-1:0]     align_eff;
	logic [ALIGN_W-1:0]     align_mask;
	logic [AXW-1:0]         aligned_d;
	logic [OFS_W-1:0]       tail;
	logic [FENCE_W-1:0]     front_fence;
	logic [SUMW-1:0]        end_sum;
	logic                   too_big;
	logic                   at_or_past_tail;
	logic                   nospace;
	logic [OFS_W-1:0]       where;
	logic [HSW-1:0]         head_sum;
	logic                   pend_full;
	logic [IIW-1:0]         rslot_inc;
	logic [IIW-1:0]         wslot_inc;
	logic                   rslot_wrap;
	logic                   wslot_wrap;

	// finishing result of the current item
	logic                   fin;
	logic [1:0]             fin_status;
	logic [OFS_W-1:0]       fin_offset;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign offset    = offset_q;

	// pending offsets, indexed by list position
	frsa_ram #(
		.DEPTH (PENDING_DEPTH),
		.WIDTH (OFS_W)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pcount_q[PIW-1:0]),
		.wdata (where),
		.raddr (pidx_q[PIW-1:0]),
		.rdata (pend_rdata)
	);

	// in-flight fifo: {offset, fence} per slot; the read side always looks at the front slot
	frsa_ram #(
		.DEPTH (INFLIGHT_DEPTH),
		.WIDTH (IFL_W)
	) u_ifl_ram (
		.clk   (clk),
		.we    (ifl_we),
		.waddr (wslot_q),
		.wdata ({pend_rdata, fence_q}),
		.raddr (rslot_q),
		.rdata (ifl_rdata)
	);

	// fifo occupancy from slot and phase
	assign fifo_empty = (rslot_q == wslot_q) && (rph_q == wph_q);
	assign fifo_full  = (rslot_q == wslot_q) && (rph_q != wph_q);

	assign rslot_wrap = (rslot_q == IIW'(INFLIGHT_DEPTH - 1));
	assign wslot_wrap = (wslot_q == IIW'(INFLIGHT_DEPTH - 1));
	assign rslot_inc  = rslot_wrap ? '0 : rslot_q + IIW'(1);
	assign wslot_inc  = wslot_wrap ? '0 : wslot_q + IIW'(1);

	// head rounded up at accept time; alignment zero counts as one
	assign align_eff  = (alignment == '0) ? ALIGN_W'(1) : alignment;
	assign align_mask = align_eff - ALIGN_W'(1);
	assign aligned_d  = (AXW'(head_q) + AXW'(align_mask)) & ~AXW'(align_mask);

	// placement, in the cycle after accept, once the front slot has been read
	assign tail        = fifo_empty ? '0 : ifl_rdata[IFL_W-1 -: OFS_W];
	assign front_fence = ifl_rdata[FENCE_W-1:0];
	assign end_sum     = SUMW'(aligned_q) + SUMW'(size_q);
	assign too_big     = (size_q > ring_size_q);
	assign at_or_past_tail = (SUMW'(aligned_q) >= SUMW'(tail));

	always_comb begin
		nospace = 1'b0;
		where   = OFS_W'(aligned_q);
		if (too_big) begin
			nospace = 1'b1;
		end else if (at_or_past_tail) begin
			// past the end of the ring: wrap to offset zero if it fits below the tail
			if (end_sum > SUMW'(ring_size_q)) begin
				if (size_q > tail) begin
					nospace = 1'b1;
				end else begin
					where = '0;
				end
			end
		end else if (end_sum > SUMW'(tail)) begin
			nospace = 1'b1;
		end
	end

	assign head_sum  = HSW'(where) + HSW'(size_q);
	assign pend_full = (pcount_q >= PCW'(PENDING_DEPTH));

	// sequencer
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		pcount_d   = pcount_q;
		pidx_d     = pidx_q;
		rslot_d    = rslot_q;
		rph_d      = rph_q;
		wslot_d    = wslot_q;
		wph_d      = wph_q;
		pend_we    = 1'b0;
		ifl_we     = 1'b0;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_offset = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_ALLOC: begin
							state_d = S_ALLOC;
						end
						ACT_SUBMIT: begin
							pidx_d  = '0;
							state_d = S_SUB_RD;
						end
						ACT_BEGIN: begin
							state_d = S_BF_RD;
						end
						default: begin
							// unused request code answers at once
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				fin = 1'b1;
				if (nospace) begin
					fin_status = ST_NOSPACE;
				end else begin
					// head moves even when the pending list turns out full
					head_d = head_sum[OFFSET_BITS-1:0];
					if (pend_full) begin
						fin_status = ST_FULL;
					end else begin
						pend_we    = 1'b1;
						pcount_d   = pcount_q + PCW'(1);
						fin_offset = where;
					end
				end
			end
			S_SUB_RD: begin
				if (pidx_q < pcount_q) begin
					state_d = S_SUB_WR;
				end else begin
					pcount_d = '0;
					fin      = 1'b1;
				end
			end
			S_SUB_WR: begin
				if (fifo_full) begin
					// entries already moved stay; pending list is kept
					fin        = 1'b1;
					fin_status = ST_FULL;
				end else begin
					ifl_we  = 1'b1;
					wslot_d = wslot_inc;
					wph_d   = wph_q ^ wslot_wrap;
					pidx_d  = pidx_q + PCW'(1);
					state_d = S_SUB_RD;
				end
			end
			S_BF_RD: begin
				if (fifo_empty) begin
					fin = 1'b1;
				end else begin
					state_d = S_BF_CMP;
				end
			end
			S_BF_CMP: begin
				if (front_fence > fence_q) begin
					fin = 1'b1;
				end else begin
					rslot_d = rslot_inc;
					rph_d   = rph_q ^ rslot_wrap;
					state_d = S_BF_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// hand the result to the output register, or park it until there is room
		if (fin) begin
			state_d = out_free ? S_IDLE : S_DONE;
		end
	end

	assign out_load    = (fin || (state_q == S_DONE)) && out_free;
	assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_size_q <= RING_SIZE_RESET;
			head_q      <= '0;
			pcount_q    <= '0;
			pidx_q      <= '0;
			rslot_q     <= '0;
			rph_q       <= 1'b0;
			wslot_q     <= '0;
			wph_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			pcount_q    <= pcount_d;
			pidx_q      <= pidx_d;
			rslot_q     <= rslot_d;
			rph_q       <= rph_d;
			wslot_q     <= wslot_d;
			wph_q       <= wph_d;
			out_valid_q <= out_valid_d;
			if (cfg_wen) begin
				ring_size_q <= cfg_wdata;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			size_q    <= alloc_size;
			fence_q   <= fence;
			aligned_q <= aligned_d;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_offset_q <= fin_offset;
		end
		if (out_load) begin
			status_q <= fin ? fin_status : res_status_q;
			offset_q <= fin ? fin_offset : res_offset_q;
		end
	end

endmodule

`default_nettype wire

FILE: design/frsa_checker.sv
`default_nettype none

`include "fenced_ring_staging_allocator_core_macros.svh"

module frsa_checker
	import frsa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic [1:0]       action,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [1:0]       status,
	input wire logic [OFS_W-1:0] offset
);

	// request beat with a defined code; the unused code may answer at once
	logic busy_beat;

	assign busy_beat = in_valid && !in_stall && (action <= ACT_BEGIN);

	// a held result beat does not change
	`FRSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(offset))

	// only a successful allocate carries an offset; a failed result shows offset zero
	`FRSA_ASSERT_NOW(a_fail_zero_ofs, out_valid && (status != ST_OK), offset == '0)

	// one item at a time: busy right after a request beat
	`FRSA_ASSERT_NEXT(a_busy_after_accept, busy_beat, in_stall)

endmodule

bind fenced_ring_staging_allocator_core frsa_checker u_frsa_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench
	import frsa_pkg::*;
();

	// block sizes, kept equal to the defaults of the core
	localparam int PEND_MAX     = 64;
	localparam int FLIGHT_MAX   = 256;
	localparam int OFS_BITS     = 32;

	// the request code that the block takes and ignores
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	// settling time at the end, sized for a begin frame that retires a full fifo
	localparam int DRAIN_CYCLES = 600;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int PHASE_BEATS  = 130;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFS_W-1:0]  offset;
	} result_t;

	// one submitted allocation waiting for its fence
	typedef struct packed {
		logic [OFS_W-1:0]   ofs;
		logic [FENCE_W-1:0] fence;
	} flight_t;

	typedef struct {
		logic [1:0]         act;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		logic [FENCE_W-1:0] fence;
		bit                 typed;
		result_t            want;
	} step_row_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wen     = 1'b0;
	logic [31:0]        cfg_wdata   = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         action      = ACT_ALLOC;
	logic [SIZE_W-1:0]  alloc_size  = '0;
	logic [ALIGN_W-1:0] alignment   = '0;
	logic [FENCE_W-1:0] fence       = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [1:0]         status;
	logic [OFS_W-1:0]   offset;

	// shadow of the allocator state, updated as each beat is accepted
	logic [31:0]        ring_bytes = RING_SIZE_RESET;
	logic [OFS_W-1:0]   head_ofs   = '0;
	logic [OFS_W-1:0]   pending_ofs[$];
	flight_t            in_flight[$];

	result_t            awaited_results[$];
	step_row_t          directed_steps[$];

	logic [FENCE_W-1:0] fence_next;
	bit                 gaps_on = 1'b1;
	int                 beats_sent;
	int                 mismatch_count;
	int                 cycle_count;

	always #5 clk = ~clk;

	fenced_ring_staging_allocator_core #(
		.PENDING_DEPTH  (PEND_MAX),
		.INFLIGHT_DEPTH (FLIGHT_MAX),
		.OFFSET_BITS    (OFS_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.alloc_size  (alloc_size),
		.alignment   (alignment),
		.fence       (fence),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.offset      (offset)
	);

	// place, submit or retire against the shadow state, giving the one result
	task automatic predict_ring_result(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
			input logic [ALIGN_W-1:0] al, input logic [FENCE_W-1:0] fe, output result_t res);
		logic [63:0] step;
		logic [63:0] aligned;
		logic [63:0] tail;
		logic [63:0] where;
		int          i;
		bit          full;
		res = '0;
		res.status = ST_OK;
		full = 1'b0;
		case (act)
			ACT_ALLOC: begin
				// zero alignment behaves as byte alignment
				step = (al == '0) ? 64'd1 : {{(64-ALIGN_W){1'b0}}, al};
				if (sz > ring_bytes) begin
					res.status = ST_NOSPACE;
				end else begin
					// round up with the bits of step-1 cleared, even for non powers of two
					aligned = ({32'd0, head_ofs} + step - 64'd1) & ~(step - 64'd1);
					tail = (in_flight.size() == 0) ? 64'd0 : {32'd0, in_flight[0].ofs};
					where = aligned;
					if (aligned >= tail) begin
						// past the end of the ring: wrap to zero if it fits below the tail
						if (aligned + sz > {32'd0, ring_bytes}) begin
							if ({32'd0, sz} > tail)
								res.status = ST_NOSPACE;
							else
								where = 64'd0;
						end
					end else if (aligned + sz > tail) begin
						res.status = ST_NOSPACE;
					end
					if (res.status == ST_OK) begin
						// head moves even when the pending list turns out full
						head_ofs = where[OFS_W-1:0] + sz;
						if (pending_ofs.size() >= PEND_MAX) begin
							res.status = ST_FULL;
						end else begin
							pending_ofs.push_back(where[OFS_W-1:0]);
							res.offset = where[OFS_W-1:0];
						end
					end
				end
			end
			ACT_SUBMIT: begin
				// entries moved before the fifo fills stay; the pending list is kept whole
				for (i = 0; i < pending_ofs.size() && !full; i++) begin
					if (in_flight.size() >= FLIGHT_MAX)
						full = 1'b1;
					else
						in_flight.push_back('{ofs: pending_ofs[i], fence: fe});
				end
				if (full)
					res.status = ST_FULL;
				else
					pending_ofs.delete();
			end
			ACT_BEGIN: begin
				while (in_flight.size() != 0 && in_flight[0].fence <= fe)
					void'(in_flight.pop_front());
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
		mismatch_count++;
	endtask

	// drive one request beat and log its expected result once accepted
	task automatic send_beat(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
			input logic [ALIGN_W-1:0] al, input logic [FENCE_W-1:0] fe,
			input bit typed = 1'b0, input result_t want = '0);
		result_t predicted;
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		action      = act;
		alloc_size  = sz;
		alignment   = al;
		fence       = fe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_ring_result(act, sz, al, fe, predicted);
		awaited_results.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	task automatic add_step(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
			input logic [ALIGN_W-1:0] al, input logic [FENCE_W-1:0] fe, input bit typed,
			input logic [1:0] st, input logic [OFS_W-1:0] ofs);
		step_row_t r;
		r.act   = act;
		r.size  = sz;
		r.align = al;
		r.fence = fe;
		r.typed = typed;
		r.want  = '{status: st, offset: ofs};
		directed_steps.push_back(r);
	endtask

	// hold off the sender until every result is back
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_ring_size(input logic [31:0] bytes);
		drain_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_wdata = bytes;
		@(negedge clk);
		cfg_wen    = 1'b0;
		ring_bytes = bytes;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly small power-of-two alignments, now and then up to 64 KiB
	function automatic logic [ALIGN_W-1:0] pick_align();
		int unsigned k;
		k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 4);
		return 17'd1 << k;
	endfunction

	// sizes scaled to the ring, with an occasional near-full request
	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned shift;
		logic [31:0] cap;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(ring_bytes >> 1, ring_bytes);
		shift = $urandom_range(2, 10);
		cap = ring_bytes >> shift;
		return $urandom_range(0, cap);
	endfunction

	// a frame: a few allocations, one submit, sometimes a lagging retire
	task automatic run_frame();
		int n;
		n = $urandom_range(1, 8);
		repeat (n)
			send_beat(ACT_ALLOC, pick_size(), pick_align(), rand64());
		send_beat(ACT_SUBMIT, $urandom, 17'($urandom), fence_next);
		fence_next += $urandom_range(1, 2);
		if ($urandom_range(0, 2) == 0)
			send_beat(ACT_BEGIN, $urandom, 17'($urandom), fence_next - $urandom_range(1, 12));
	endtask

	// overfill the pending list, then submit, with no retire in between
	task automatic run_fill(input int rounds);
		repeat (rounds) begin
			repeat ($urandom_range(66, 70))
				send_beat(ACT_ALLOC, $urandom_range(0, 2), 17'd1 << $urandom_range(0, 2),
					rand64());
			send_beat(ACT_SUBMIT, $urandom, 17'($urandom), fence_next);
			fence_next++;
		end
	endtask

	// receiver stalls at random except in the no-gap stretch
	always @(negedge clk)
		out_stall = gaps_on && ($urandom_range(0, 99) < 33);

	// every result beat is checked against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result beat", {62'd0, status}, 64'd0);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					flag_mismatch("status", {62'd0, status}, {62'd0, want.status});
				if (offset !== want.offset)
					flag_mismatch("offset", {32'd0, offset}, {32'd0, want.offset});
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int ph;
		int phase_start;
		int pick;
		logic [31:0] ring_choice;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed walk from reset with the default 1 MiB ring
		// oversize request, then plain placements
		add_step(ACT_ALLOC, 32'hFFFF_FFFF, 17'd1, 64'd0, 1, ST_NOSPACE, 32'd0);
		add_step(ACT_ALLOC, 32'd16, 17'd1, 64'd0, 1, ST_OK, 32'd0);
		add_step(ACT_ALLOC, 32'd8, 17'd64, 64'd0, 1, ST_OK, 32'd64);
		// zero alignment acts as one
		add_step(ACT_ALLOC, 32'd1, 17'd0, 64'd0, 1, ST_OK, 32'd72);
		// alignment that is not a power of two
		add_step(ACT_ALLOC, 32'd4, 17'd3, 64'd0, 0, ST_OK, 32'd0);
		add_step(ACT_ALLOC, 32'd1, 17'd65536, 64'd0, 1, ST_OK, 32'd65536);
		add_step(ACT_ALLOC, 32'd0, 17'h1FFFF, 64'd0, 0, ST_OK, 32'd0);
		// exactly the ring size but the head is not at zero and the fifo is empty
		add_step(ACT_ALLOC, 32'd1048576, 17'd1, 64'd0, 1, ST_NOSPACE, 32'd0);
		add_step(ACT_ALLOC, 32'd0, 17'd1, 64'd0, 0, ST_OK, 32'd0);
		add_step(ACT_SUBMIT, 32'd0, 17'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 32'd0);
		// retire nothing, nothing, then everything
		add_step(ACT_BEGIN, 32'd0, 17'd1, 64'd0, 1, ST_OK, 32'd0);
		add_step(ACT_BEGIN, 32'd0, 17'd1, 64'hFFFF_FFFF_FFFF_FFFE, 1, ST_OK, 32'd0);
		add_step(ACT_BEGIN, 32'd0, 17'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 32'd0);
		add_step(ACT_ALLOC, 32'h8_0000, 17'd1, 64'd0, 0, ST_OK, 32'd0);
		add_step(ACT_SUBMIT, 32'd0, 17'd1, 64'd10, 1, ST_OK, 32'd0);
		// tail now sits at 0x20001: too big to wrap
		add_step(ACT_ALLOC, 32'h8_0000, 17'd1, 64'd0, 1, ST_NOSPACE, 32'd0);
		add_step(ACT_ALLOC, 32'h4_0000, 17'd1, 64'd0, 0, ST_OK, 32'd0);
		// wraps to zero
		add_step(ACT_ALLOC, 32'h2_0000, 17'd1, 64'd0, 1, ST_OK, 32'd0);
		// head below tail: one byte too many, then an exact fit
		add_step(ACT_ALLOC, 32'd2, 17'd1, 64'd0, 1, ST_NOSPACE, 32'd0);
		add_step(ACT_ALLOC, 32'd1, 17'd1, 64'd0, 1, ST_OK, 32'h2_0000);
		add_step(ACT_SUBMIT, 32'd0, 17'd1, 64'd20, 1, ST_OK, 32'd0);
		add_step(ACT_BEGIN, 32'd0, 17'd1, 64'd10, 1, ST_OK, 32'd0);
		add_step(ACT_IGNORED, 32'hFFFF_FFFF, 17'h1FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1,
			ST_OK, 32'd0);
		// submit with nothing pending
		add_step(ACT_SUBMIT, 32'd0, 17'd1, 64'd0, 1, ST_OK, 32'd0);
		add_step(ACT_BEGIN, 32'd0, 17'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 32'd0);

		foreach (directed_steps[i])
			send_beat(directed_steps[i].act, directed_steps[i].size, directed_steps[i].align,
				directed_steps[i].fence, directed_steps[i].typed, directed_steps[i].want);

		// random phases, each under its own ring size
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				1: ring_choice = 32'hFFFF_FFFF;
				2: ring_choice = 32'd1;
				3: ring_choice = RING_SIZE_RESET;
				4: ring_choice = 32'h1000;
				5: ring_choice = 32'd256;
				6: ring_choice = $urandom_range(32'h1_0000, 32'h100_0000);
				7: ring_choice = $urandom | 32'd1;
				default: ring_choice = RING_SIZE_RESET;
			endcase
			// the first phase keeps the reset value
			if (ph != 0)
				set_ring_size(ring_choice);
			// one long stretch with no gaps and no stalls
			gaps_on = (ph != 3);
			fence_next = rand64();
			if (ph == 4) begin
				// empty the fifo and wrap a head past the new ring end to zero, then run both lists into full
				send_beat(ACT_BEGIN, $urandom, 17'($urandom), 64'hFFFF_FFFF_FFFF_FFFF);
				send_beat(ACT_ALLOC, 32'd0, 17'd1, rand64());
				run_fill(5);
			end
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					run_frame();
				else if (pick < 67)
					run_fill($urandom_range(1, 2));
				else if (pick < 85)
					send_beat(ACT_BEGIN, $urandom, 17'($urandom),
						($urandom_range(0, 3) == 0) ? fence_next
						: fence_next - $urandom_range(0, 20));
				else
					// noise: any code, any field value
					send_beat(2'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? $urandom : pick_size(),
						17'($urandom), rand64());
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
